>>> src/dtna_pkg.sv
`default_nettype none

package dtna_pkg;

   localparam logic [1:0] KIND_SET  = 2'd0;
   localparam logic [1:0] KIND_ADD  = 2'd1;
   localparam logic [1:0] KIND_SUB  = 2'd2;
   localparam logic [1:0] KIND_KEEP = 2'd3;

   localparam logic [8:0] DIVISOR_SEC  = 9'd60;
   localparam logic [8:0] DIVISOR_MIN  = 9'd60;
   localparam logic [8:0] DIVISOR_HOUR = 9'd24;
   localparam logic [8:0] DIVISOR_MON  = 9'd12;
   localparam logic [8:0] DIVISOR_YEAR = 9'd400;
   localparam logic [8:0] RES_LAST     = 9'd399;

   // divide one 16-bit digit per step; the reciprocal is exact below 400 * 2**16
   localparam int DIGIT_BITS  = 16;
   localparam int RECIP_SHIFT = 34;
   localparam logic [30:0] RECIP_SEC  = 31'(((longint'(1) << RECIP_SHIFT)
                                            + longint'(DIVISOR_SEC) - 1)
                                           / longint'(DIVISOR_SEC));
   localparam logic [30:0] RECIP_HOUR = 31'(((longint'(1) << RECIP_SHIFT)
                                            + longint'(DIVISOR_HOUR) - 1)
                                           / longint'(DIVISOR_HOUR));
   localparam logic [30:0] RECIP_MON  = 31'(((longint'(1) << RECIP_SHIFT)
                                            + longint'(DIVISOR_MON) - 1)
                                           / longint'(DIVISOR_MON));
   localparam logic [30:0] RECIP_YEAR = 31'(((longint'(1) << RECIP_SHIFT)
                                            + longint'(DIVISOR_YEAR) - 1)
                                           / longint'(DIVISOR_YEAR));

   localparam logic [9:0] DAYS_COMMON = 10'd365;
   localparam logic [9:0] DAYS_LEAP   = 10'd366;

   localparam logic [15:0] RESET_YEAR = 16'd2000;

   typedef enum logic [2:0] {
      SEL_SEC  = 3'd0,
      SEL_MIN  = 3'd1,
      SEL_HOUR = 3'd2,
      SEL_MON  = 3'd3,
      SEL_YEAR = 3'd4
   } sel_type;

   typedef struct packed {
      logic    load;
      logic    div_start;
      logic    div_apply;
      sel_type sel;
      logic    walk;
      logic    commit;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic div_done;
      logic walk_done;
   } status_type;

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         4'd1:    len = leap ? 5'd29 : 5'd28;
         4'd3:    len = 5'd30;
         4'd5:    len = 5'd30;
         4'd8:    len = 5'd30;
         4'd10:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
      logic [8:0] sum;
      case (m)
         4'd0:    sum = 9'd0;
         4'd1:    sum = 9'd31;
         4'd2:    sum = 9'd59;
         4'd3:    sum = 9'd90;
         4'd4:    sum = 9'd120;
         4'd5:    sum = 9'd151;
         4'd6:    sum = 9'd181;
         4'd7:    sum = 9'd212;
         4'd8:    sum = 9'd243;
         4'd9:    sum = 9'd273;
         4'd10:   sum = 9'd304;
         default: sum = 9'd334;
      endcase
      if (m > 4'd1 && leap) begin
         sum = sum + 9'd1;
      end
      return sum;
   endfunction

   // low2 is the year modulo 4, res the year modulo 400
   function automatic logic is_leap(input logic [1:0] low2, input logic [8:0] res);
      return (low2 == 2'd0) && (res != 9'd100) && (res != 9'd200) && (res != 9'd300);
   endfunction

endpackage

`default_nettype wire

>>> src/dtna_div.sv
`default_nettype none

module dtna_div #(
   parameter int W = 19
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic signed [W-1:0] dividend,
   input  wire logic        [8:0]   divisor,
   output logic                     busy,
   output logic                     done,
   output logic signed      [W-1:0] quot,
   output logic             [8:0]   rem
);

   import dtna_pkg::*;

   localparam int ND  = (W - 1 + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int PW  = ND * DIGIT_BITS;
   localparam int CW  = (ND > 1) ? $clog2(ND) : 1;
   localparam int VW  = 9 + DIGIT_BITS;
   localparam int PRW = VW + 31;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              phase_ff, phase_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [PW-1:0]     mag_ff, mag_in;
   logic [8:0]        rem_ff, rem_in;
   logic [8:0]        div_ff, div_in;
   logic [30:0]       recip_ff, recip_in;
   logic [DIGIT_BITS-1:0] qd_ff, qd_in;
   logic              neg_ff, neg_in;
   logic [VW-1:0]     val_w, back_w;
   logic [PRW-1:0]    prod;
   logic [W-1:0]      neg_dividend;
   logic signed [W-1:0] q_mag;

   always_comb begin
      busy_in      = busy_ff;
      done_in      = 1'b0;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      recip_in     = recip_ff;
      qd_in        = qd_ff;
      neg_in       = neg_ff;
      neg_dividend = -dividend;
      // partial remainder followed by the next digit, MSB digit first
      val_w        = {rem_ff, mag_ff[PW-1 -: DIGIT_BITS]};
      prod         = PRW'(val_w) * PRW'(recip_ff);
      back_w       = VW'(qd_ff) * VW'(div_ff);
      if (start) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
         neg_in   = dividend[W-1];
         mag_in   = PW'(dividend[W-1] ? neg_dividend[W-2:0] : dividend[W-2:0]);
         rem_in   = '0;
         div_in   = divisor;
         cnt_in   = CW'(ND - 1);
         case (divisor)
            DIVISOR_HOUR: recip_in = RECIP_HOUR;
            DIVISOR_MON:  recip_in = RECIP_MON;
            DIVISOR_YEAR: recip_in = RECIP_YEAR;
            default:      recip_in = RECIP_SEC;
         endcase
      end else if (busy_ff) begin
         if (!phase_ff) begin
            qd_in    = prod[RECIP_SHIFT +: DIGIT_BITS];
            phase_in = 1'b1;
         end else begin
            rem_in   = 9'(val_w - back_w);
            mag_in   = (mag_ff << DIGIT_BITS) | PW'(qd_ff);
            phase_in = 1'b0;
            cnt_in   = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      phase_ff <= phase_in;
      cnt_ff   <= cnt_in;
      mag_ff   <= mag_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      recip_ff <= recip_in;
      qd_ff    <= qd_in;
      neg_ff   <= neg_in;
   end

   // turn the truncated magnitude result into floor division
   always_comb begin
      q_mag = $signed({1'b0, mag_ff[W-2:0]});
      if (neg_ff && rem_ff != '0) begin
         quot = -q_mag - W'(1);
         rem  = div_ff - rem_ff;
      end else if (neg_ff) begin
         quot = -q_mag;
         rem  = '0;
      end else begin
         quot = q_mag;
         rem  = rem_ff;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

>>> src/dtna_datapath.sv
`default_nettype none

module dtna_datapath #(
   parameter int YEAR_BITS = 16,
   parameter int ARG_BITS  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire dtna_pkg::cmd_type            cmd,
   output dtna_pkg::status_type              status,
   input  wire logic        [1:0]            kind,
   input  wire logic signed [ARG_BITS-1:0]   arg_year,
   input  wire logic        [ARG_BITS-1:0]   arg_month,
   input  wire logic        [ARG_BITS-1:0]   arg_day,
   input  wire logic        [ARG_BITS-1:0]   arg_hour,
   input  wire logic        [ARG_BITS-1:0]   arg_minute,
   input  wire logic        [ARG_BITS-1:0]   arg_second,
   output logic signed      [YEAR_BITS-1:0]  out_year,
   output logic             [3:0]            out_month,
   output logic             [4:0]            out_day,
   output logic             [4:0]            out_hour,
   output logic             [5:0]            out_minute,
   output logic             [5:0]            out_second,
   output logic             [8:0]            day_of_year,
   output logic                              leap_year,
   output logic                              year_wrapped
);

   import dtna_pkg::*;

   localparam int W = ((YEAR_BITS > ARG_BITS) ? YEAR_BITS : ARG_BITS) + 3;
   localparam longint YMinL = -(longint'(1) <<< (YEAR_BITS - 1));
   localparam int ResMin = int'(((YMinL % 400) + 400) % 400);
   localparam int ResMax = int'((((-YMinL - 1) % 400) + 400) % 400);
   localparam logic [YEAR_BITS-1:0] YMin = {1'b1, {(YEAR_BITS-1){1'b0}}};
   localparam logic [YEAR_BITS-1:0] YMax = {1'b0, {(YEAR_BITS-1){1'b1}}};

   logic signed [YEAR_BITS-1:0] y_ff, y_in;
   logic signed [W-1:0]         mo_ff, mo_in, d_ff, d_in, h_ff, h_in;
   logic signed [W-1:0]         mi_ff, mi_in, s_ff, s_in;
   logic [8:0]                  res_ff, res_in;
   logic                        wrap_ff, wrap_in;

   logic signed [YEAR_BITS-1:0] cur_year_ff, cur_year_in;
   logic [3:0]                  cur_mo_ff, cur_mo_in;
   logic [4:0]                  cur_d_ff, cur_d_in, cur_h_ff, cur_h_in;
   logic [5:0]                  cur_mi_ff, cur_mi_in, cur_s_ff, cur_s_in;
   logic [8:0]                  cur_res_ff, cur_res_in;

   logic signed [YEAR_BITS-1:0] oy_ff, oy_in;
   logic [3:0]                  omo_ff, omo_in;
   logic [4:0]                  od_ff, od_in, oh_ff, oh_in;
   logic [5:0]                  omi_ff, omi_in, os_ff, os_in;
   logic [8:0]                  odoy_ff, odoy_in;
   logic                        oleap_ff, oleap_in, owrap_ff, owrap_in;

   logic signed [W-1:0] ay_w, amo_w, ad_w, ah_w, ami_w, as_w;
   logic signed [W-1:0] cy_w, cmo_w, cd_w, ch_w, cmi_w, cs_w;
   logic signed [W-1:0] y_sum, y_w, q_sum, div_op, quot;
   logic [8:0]          divisor, rem;
   logic                div_busy, div_done;
   logic [YEAR_BITS-1:0] y_low;

   logic [3:0]          mo4;
   logic                leap_cur, leap_prev, d_neg;
   logic [YEAR_BITS-1:0] py, ny;
   logic [8:0]          res_prev, res_next;
   logic [9:0]          len_cur, len_prev;
   logic signed [W-1:0] len_cur_w, len_prev_w, dim_cur_w, dim_back_w;
   logic                year_up, fits;

   assign ay_w  = W'(arg_year);
   assign amo_w = $signed(W'(arg_month));
   assign ad_w  = $signed(W'(arg_day));
   assign ah_w  = $signed(W'(arg_hour));
   assign ami_w = $signed(W'(arg_minute));
   assign as_w  = $signed(W'(arg_second));
   assign cy_w  = W'(cur_year_ff);
   assign cmo_w = $signed(W'(cur_mo_ff));
   assign cd_w  = $signed(W'(cur_d_ff));
   assign ch_w  = $signed(W'(cur_h_ff));
   assign cmi_w = $signed(W'(cur_mi_ff));
   assign cs_w  = $signed(W'(cur_s_ff));
   assign y_w   = W'(y_ff);

   always_comb begin
      case (cmd.sel)
         SEL_SEC: begin
            div_op = s_ff;
            divisor = DIVISOR_SEC;
         end
         SEL_MIN: begin
            div_op = mi_ff;
            divisor = DIVISOR_MIN;
         end
         SEL_HOUR: begin
            div_op = h_ff;
            divisor = DIVISOR_HOUR;
         end
         SEL_MON: begin
            div_op = mo_ff;
            divisor = DIVISOR_MON;
         end
         default: begin
            div_op = y_w;
            divisor = DIVISOR_YEAR;
         end
      endcase
   end

   dtna_div #(.W(W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_op),
      .divisor  (divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quot     (quot),
      .rem      (rem)
   );

   // calendar walk terms
   always_comb begin
      mo4       = mo_ff[3:0];
      d_neg     = d_ff[W-1];
      leap_cur  = is_leap(y_ff[1:0], res_ff);
      py        = y_ff - YEAR_BITS'(1);
      ny        = y_ff + YEAR_BITS'(1);
      if (y_ff == YMin) begin
         res_prev = 9'(ResMax);
      end else if (res_ff == '0) begin
         res_prev = RES_LAST;
      end else begin
         res_prev = res_ff - 9'd1;
      end
      if (y_ff == YMax) begin
         res_next = 9'(ResMin);
      end else if (res_ff == RES_LAST) begin
         res_next = '0;
      end else begin
         res_next = res_ff + 9'd1;
      end
      leap_prev  = is_leap(py[1:0], res_prev);
      len_cur    = leap_cur ? DAYS_LEAP : DAYS_COMMON;
      len_prev   = leap_prev ? DAYS_LEAP : DAYS_COMMON;
      len_cur_w  = $signed(W'(len_cur));
      len_prev_w = $signed(W'(len_prev));
      dim_cur_w  = $signed(W'(month_len(mo4, leap_cur)));
      dim_back_w = $signed(W'(month_len(mo4 - 4'd1, leap_cur)));
      year_up    = (mo4 == 4'd0) && (d_ff >= len_cur_w);
      fits       = d_ff < dim_cur_w;
   end

   assign status.div_busy  = div_busy;
   assign status.div_done  = div_done;
   assign status.walk_done = !d_neg && !year_up && fits;

   always_comb begin
      y_in   = y_ff;
      mo_in  = mo_ff;
      d_in   = d_ff;
      h_in   = h_ff;
      mi_in  = mi_ff;
      s_in   = s_ff;
      res_in = res_ff;
      wrap_in = wrap_ff;
      y_sum  = '0;
      q_sum  = y_w + quot;
      y_low  = '0;
      if (cmd.load) begin
         case (kind)
            KIND_SET: begin
               y_sum = ay_w;
               mo_in = amo_w;
               d_in  = ad_w;
               h_in  = ah_w;
               mi_in = ami_w;
               s_in  = as_w;
            end
            KIND_ADD: begin
               y_sum = cy_w + ay_w;
               mo_in = cmo_w + amo_w;
               d_in  = cd_w + ad_w;
               h_in  = ch_w + ah_w;
               mi_in = cmi_w + ami_w;
               s_in  = cs_w + as_w;
            end
            KIND_SUB: begin
               y_sum = cy_w - ay_w;
               mo_in = cmo_w - amo_w;
               d_in  = cd_w - ad_w;
               h_in  = ch_w - ah_w;
               mi_in = cmi_w - ami_w;
               s_in  = cs_w - as_w;
            end
            default: begin
               y_sum = cy_w;
               mo_in = cmo_w;
               d_in  = cd_w;
               h_in  = ch_w;
               mi_in = cmi_w;
               s_in  = cs_w;
            end
         endcase
         y_low   = y_sum[YEAR_BITS-1:0];
         y_in    = $signed(y_low);
         wrap_in = W'($signed(y_low)) != y_sum;
         res_in  = cur_res_ff;
      end else if (cmd.div_apply) begin
         case (cmd.sel)
            SEL_SEC: begin
               s_in  = $signed(W'(rem));
               mi_in = mi_ff + quot;
            end
            SEL_MIN: begin
               mi_in = $signed(W'(rem));
               h_in  = h_ff + quot;
            end
            SEL_HOUR: begin
               h_in = $signed(W'(rem));
               d_in = d_ff + quot;
            end
            SEL_MON: begin
               mo_in = $signed(W'(rem));
               y_low = q_sum[YEAR_BITS-1:0];
               y_in  = $signed(y_low);
               if (W'($signed(y_low)) != q_sum) begin
                  wrap_in = 1'b1;
               end
            end
            default: begin
               res_in = rem;
            end
         endcase
      end else if (cmd.walk) begin
         if (d_neg) begin
            if (mo4 == 4'd0) begin
               // step back over a whole year, or into December
               y_in   = $signed(py);
               res_in = res_prev;
               if (y_ff == YMin) begin
                  wrap_in = 1'b1;
               end
               if (d_ff + len_prev_w <= $signed(W'(0))) begin
                  d_in = d_ff + len_prev_w;
               end else begin
                  mo_in = $signed(W'(4'd11));
                  d_in  = d_ff + $signed(W'(5'd31));
               end
            end else begin
               mo_in = mo_ff - $signed(W'(1));
               d_in  = d_ff + dim_back_w;
            end
         end else if (year_up) begin
            d_in   = d_ff - len_cur_w;
            y_in   = $signed(ny);
            res_in = res_next;
            if (y_ff == YMax) begin
               wrap_in = 1'b1;
            end
         end else if (!fits) begin
            d_in = d_ff - dim_cur_w;
            if (mo4 == 4'd11) begin
               mo_in  = '0;
               y_in   = $signed(ny);
               res_in = res_next;
               if (y_ff == YMax) begin
                  wrap_in = 1'b1;
               end
            end else begin
               mo_in = mo_ff + $signed(W'(1));
            end
         end
      end
   end

   always_comb begin
      cur_year_in = cur_year_ff;
      cur_mo_in   = cur_mo_ff;
      cur_d_in    = cur_d_ff;
      cur_h_in    = cur_h_ff;
      cur_mi_in   = cur_mi_ff;
      cur_s_in    = cur_s_ff;
      cur_res_in  = cur_res_ff;
      oy_in       = oy_ff;
      omo_in      = omo_ff;
      od_in       = od_ff;
      oh_in       = oh_ff;
      omi_in      = omi_ff;
      os_in       = os_ff;
      odoy_in     = odoy_ff;
      oleap_in    = oleap_ff;
      owrap_in    = owrap_ff;
      if (cmd.commit) begin
         cur_year_in = y_ff;
         cur_mo_in   = mo4;
         cur_d_in    = d_ff[4:0];
         cur_h_in    = h_ff[4:0];
         cur_mi_in   = mi_ff[5:0];
         cur_s_in    = s_ff[5:0];
         cur_res_in  = res_ff;
         oy_in       = y_ff;
         omo_in      = mo4;
         od_in       = d_ff[4:0];
         oh_in       = h_ff[4:0];
         omi_in      = mi_ff[5:0];
         os_in       = s_ff[5:0];
         odoy_in     = days_before(mo4, leap_cur) + 9'(d_ff[4:0]);
         oleap_in    = leap_cur;
         owrap_in    = wrap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_year_ff <= YEAR_BITS'(RESET_YEAR);
         cur_mo_ff   <= '0;
         cur_d_ff    <= '0;
         cur_h_ff    <= '0;
         cur_mi_ff   <= '0;
         cur_s_ff    <= '0;
         cur_res_ff  <= '0;
      end else begin
         cur_year_ff <= cur_year_in;
         cur_mo_ff   <= cur_mo_in;
         cur_d_ff    <= cur_d_in;
         cur_h_ff    <= cur_h_in;
         cur_mi_ff   <= cur_mi_in;
         cur_s_ff    <= cur_s_in;
         cur_res_ff  <= cur_res_in;
      end
      y_ff     <= y_in;
      mo_ff    <= mo_in;
      d_ff     <= d_in;
      h_ff     <= h_in;
      mi_ff    <= mi_in;
      s_ff     <= s_in;
      res_ff   <= res_in;
      wrap_ff  <= wrap_in;
      oy_ff    <= oy_in;
      omo_ff   <= omo_in;
      od_ff    <= od_in;
      oh_ff    <= oh_in;
      omi_ff   <= omi_in;
      os_ff    <= os_in;
      odoy_ff  <= odoy_in;
      oleap_ff <= oleap_in;
      owrap_ff <= owrap_in;
   end

   assign out_year     = oy_ff;
   assign out_month    = omo_ff;
   assign out_day      = od_ff;
   assign out_hour     = oh_ff;
   assign out_minute   = omi_ff;
   assign out_second   = os_ff;
   assign day_of_year  = odoy_ff;
   assign leap_year    = oleap_ff;
   assign year_wrapped = owrap_ff;

endmodule

`default_nettype wire

>>> src/dtna_ctrl.sv
`default_nettype none

module dtna_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [1:0]           req_kind,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output dtna_pkg::cmd_type         cmd,
   input  wire dtna_pkg::status_type status
);

   import dtna_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_SEC  = 8'b0000_0010,
      ST_MIN  = 8'b0000_0100,
      ST_HOUR = 8'b0000_1000,
      ST_MON  = 8'b0001_0000,
      ST_YEAR = 8'b0010_0000,
      ST_WALK = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      started_ff, started_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      started_in    = started_ff;
      cmd.load      = 1'b0;
      cmd.div_start = 1'b0;
      cmd.div_apply = 1'b0;
      cmd.sel       = SEL_YEAR;
      cmd.walk      = 1'b0;
      cmd.commit    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = (req_kind == KIND_KEEP) ? ST_DONE : ST_SEC;
            end
         end
         ST_SEC, ST_MIN, ST_HOUR, ST_MON, ST_YEAR: begin
            case (state_ff)
               ST_SEC:  cmd.sel = SEL_SEC;
               ST_MIN:  cmd.sel = SEL_MIN;
               ST_HOUR: cmd.sel = SEL_HOUR;
               ST_MON:  cmd.sel = SEL_MON;
               default: cmd.sel = SEL_YEAR;
            endcase
            if (!started_ff) begin
               cmd.div_start = 1'b1;
               started_in    = 1'b1;
            end else if (status.div_done) begin
               cmd.div_apply = 1'b1;
               started_in    = 1'b0;
               case (state_ff)
                  ST_SEC:  state_in = ST_MIN;
                  ST_MIN:  state_in = ST_HOUR;
                  ST_HOUR: state_in = ST_MON;
                  ST_MON:  state_in = ST_YEAR;
                  default: state_in = ST_WALK;
               endcase
            end
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_walk_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && status.walk_done) |=> (state_ff == ST_DONE))
      else $error("walk finished but controller did not move to done");

   a_start_idle_div: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !status.div_busy)
      else $error("divider started while busy");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("request accepted but controller stayed idle");

endmodule

`default_nettype wire

>>> src/date_time_normalizing_adder_core.sv
`default_nettype none
// Channel  Ports   Direction  Payload
// request  req_*   in         tuser: kind; tdata: arg_year..arg_second
// result   rsp_*   out        tdata: out_year..year_wrapped
//
// One request at a time. The divider takes D = ceil((W-1)/16) digits of 16 bits,
// W = max(YEAR_BITS, ARG_BITS) + 3; the four carries and the year mod 400 share one
// divider that, per 16-bit digit, first estimates the quotient digit by reciprocal
// multiplication and then forms the remainder. The day walk moves one month or one
// whole year per cycle. A keep request (kind 3) skips the divider and the walk.
// Reset is synchronous; the date returns to 2000-01-01 00:00:00. A stalled result
// holds in its register while a new request is taken.

module date_time_normalizing_adder_core #(
   parameter int YEAR_BITS = 16,
   parameter int ARG_BITS  = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // arg_year, arg_month, arg_day, arg_hour, arg_minute, arg_second
   input  wire logic [((6*ARG_BITS+7)/8)*8-1:0] req_tdata,
   // kind
   input  wire logic [1:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // out_year, out_month, out_day, out_hour, out_minute, out_second,
   // day_of_year, leap_year, year_wrapped
   output logic [((YEAR_BITS+37+7)/8)*8-1:0] rsp_tdata
);

   import dtna_pkg::*;

   localparam int A = ARG_BITS;
   localparam int OutBits = ((YEAR_BITS + 37 + 7) / 8) * 8;

   cmd_type    cmd;
   status_type status;

   logic signed [YEAR_BITS-1:0] out_year;
   logic [3:0]                  out_month;
   logic [4:0]                  out_day, out_hour;
   logic [5:0]                  out_minute, out_second;
   logic [8:0]                  day_of_year;
   logic                        leap_year, year_wrapped;

   dtna_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   dtna_datapath #(
      .YEAR_BITS (YEAR_BITS),
      .ARG_BITS  (ARG_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .kind         (req_tuser),
      .arg_year     ($signed(req_tdata[A-1:0])),
      .arg_month    (req_tdata[2*A-1:A]),
      .arg_day      (req_tdata[3*A-1:2*A]),
      .arg_hour     (req_tdata[4*A-1:3*A]),
      .arg_minute   (req_tdata[5*A-1:4*A]),
      .arg_second   (req_tdata[6*A-1:5*A]),
      .out_year     (out_year),
      .out_month    (out_month),
      .out_day      (out_day),
      .out_hour     (out_hour),
      .out_minute   (out_minute),
      .out_second   (out_second),
      .day_of_year  (day_of_year),
      .leap_year    (leap_year),
      .year_wrapped (year_wrapped)
   );

   assign rsp_tdata = OutBits'({year_wrapped, leap_year, day_of_year, out_second,
                                out_minute, out_hour, out_day, out_month, out_year});

endmodule

`default_nettype wire

>>> sim/date_time_normalizing_adder_core_tb.sv
`default_nettype none

module date_time_normalizing_adder_core_tb;
   import dtna_pkg::*;

   localparam int YB = 16;
   localparam int AB = 16;
   localparam int REQ_W = ((6*AB+7)/8)*8;
   localparam int RSP_W = ((YB+37+7)/8)*8;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] f_year, f_month, f_day, f_hour, f_minute, f_second;
   } request_type;

   typedef struct {
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day, hour;
      logic [5:0]  minute, second;
      logic [8:0]  doy;
      logic        leap, wrapped;
   } stamp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   date_time_normalizing_adder_core #(.YEAR_BITS(YB), .ARG_BITS(AB)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   request_type pending_requests[$];
   stamp_type   expected_stamps[$];
   int       error_count = 0;
   int       sent_count = 0;
   int       checked_count = 0;
   int       send_idle_pct = 30;
   int       recv_idle_pct = 58;
   bit       hold_requests = 1'b0;

   // calendar state of the predictor
   longint cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_second;

   function automatic longint fmod(longint v, longint n);
      return ((v % n) + n) % n;
   endfunction

   function automatic longint fdiv(longint v, longint n);
      return (v - fmod(v, n)) / n;
   endfunction

   function automatic bit leap_of(longint y);
      return fmod(y, 4) == 0 && (fmod(y, 100) != 0 || fmod(y, 400) == 0);
   endfunction

   function automatic longint month_days(longint y, longint m);
      longint lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      return lens[m] + ((m == 1 && leap_of(y)) ? 1 : 0);
   endfunction

   function automatic longint fold_year(longint y, ref bit wrapped);
      longint r;
      r = longint'($signed(y[15:0]));
      if (r != y) wrapped = 1'b1;
      return r;
   endfunction

   function automatic stamp_type predict_stamp(request_type r);
      stamp_type st;
      longint y, mo, d, h, mi, s, py, len, doy;
      bit wr;
      wr = 1'b0;
      y = cal_year; mo = cal_month; d = cal_day;
      h = cal_hour; mi = cal_minute; s = cal_second;
      if (r.kind != KIND_KEEP) begin
         if (r.kind == KIND_SET) begin
            y = longint'($signed(r.f_year)); mo = r.f_month; d = r.f_day;
            h = r.f_hour; mi = r.f_minute; s = r.f_second;
         end else if (r.kind == KIND_ADD) begin
            y += longint'($signed(r.f_year)); mo += r.f_month; d += r.f_day;
            h += r.f_hour; mi += r.f_minute; s += r.f_second;
         end else begin
            y -= longint'($signed(r.f_year)); mo -= r.f_month; d -= r.f_day;
            h -= r.f_hour; mi -= r.f_minute; s -= r.f_second;
         end
         y = fold_year(y, wr);
         mi += fdiv(s, 60); s = fmod(s, 60);
         h += fdiv(mi, 60); mi = fmod(mi, 60);
         d += fdiv(h, 24); h = fmod(h, 24);
         y = fold_year(y + fdiv(mo, 12), wr); mo = fmod(mo, 12);
         while (d < 0) begin
            if (mo == 0) begin
               py = fold_year(y - 1, wr);
               len = leap_of(py) ? 366 : 365;
               if (-d >= len) begin
                  d += len;
                  y = py;
                  continue;
               end
            end
            mo -= 1;
            if (mo < 0) begin
               mo = 11;
               y = fold_year(y - 1, wr);
            end
            d += month_days(y, mo);
         end
         forever begin
            if (mo == 0) begin
               len = leap_of(y) ? 366 : 365;
               if (d >= len) begin
                  d -= len;
                  y = fold_year(y + 1, wr);
                  continue;
               end
            end
            if (d < month_days(y, mo)) break;
            d -= month_days(y, mo);
            mo += 1;
            if (mo == 12) begin
               mo = 0;
               y = fold_year(y + 1, wr);
            end
         end
         cal_year = y; cal_month = mo; cal_day = d;
         cal_hour = h; cal_minute = mi; cal_second = s;
      end
      doy = d;
      for (longint m = 0; m < mo; m++) doy += month_days(y, m);
      st.year = y[15:0]; st.month = mo[3:0]; st.day = d[4:0];
      st.hour = h[4:0]; st.minute = mi[5:0]; st.second = s[5:0];
      st.doy = doy[8:0]; st.leap = leap_of(y); st.wrapped = wr;
      return st;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("MISMATCH result %0d field %s: got %0d expected %0d",
               checked_count, field, got, want);
      error_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            expected_stamps.push_back(predict_stamp(pending_requests.pop_front()));
            sent_count++;
         end
         if (pending_requests.size() > 0 && !hold_requests &&
             $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_requests[0].kind;
            req_tdata  <= {pending_requests[0].f_second, pending_requests[0].f_minute,
                           pending_requests[0].f_hour, pending_requests[0].f_day,
                           pending_requests[0].f_month, pending_requests[0].f_year};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      stamp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_stamps.size() == 0) begin
               $display("MISMATCH unexpected result %0h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_stamps.pop_front();
               if (rsp_tdata[15:0] !== want.year)
                  report_mismatch("year", rsp_tdata[15:0], want.year);
               if (rsp_tdata[19:16] !== want.month)
                  report_mismatch("month", rsp_tdata[19:16], want.month);
               if (rsp_tdata[24:20] !== want.day)
                  report_mismatch("day", rsp_tdata[24:20], want.day);
               if (rsp_tdata[29:25] !== want.hour)
                  report_mismatch("hour", rsp_tdata[29:25], want.hour);
               if (rsp_tdata[35:30] !== want.minute)
                  report_mismatch("minute", rsp_tdata[35:30], want.minute);
               if (rsp_tdata[41:36] !== want.second)
                  report_mismatch("second", rsp_tdata[41:36], want.second);
               if (rsp_tdata[50:42] !== want.doy)
                  report_mismatch("day_of_year", rsp_tdata[50:42], want.doy);
               if (rsp_tdata[51] !== want.leap)
                  report_mismatch("leap_year", rsp_tdata[51], want.leap);
               if (rsp_tdata[52] !== want.wrapped)
                  report_mismatch("year_wrapped", rsp_tdata[52], want.wrapped);
               checked_count++;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic request_type make_request(logic [1:0] k, logic [15:0] y,
                                                logic [15:0] mo,
                                                logic [15:0] d, logic [15:0] h,
                                                logic [15:0] mi, logic [15:0] s);
      request_type r;
      r.kind = k; r.f_year = y; r.f_month = mo; r.f_day = d;
      r.f_hour = h; r.f_minute = mi; r.f_second = s;
      return r;
   endfunction

   // mostly modest durations so that the day walk stays short, a few extremes
   function automatic logic [15:0] pick_arg(int small_max);
      case ($urandom_range(9))
         0:       return 16'($urandom);
         1:       return 16'hFFFF;
         2, 3:    return 16'(small_max + 1 + $urandom_range(3 * small_max));
         default: return 16'($urandom_range(small_max));
      endcase
   endfunction

   function automatic request_type random_request();
      request_type r;
      int sel;
      sel = $urandom_range(99);
      r.kind = (sel < 25) ? KIND_SET : (sel < 60) ? KIND_ADD : (sel < 95) ? KIND_SUB
                                                               : KIND_KEEP;
      r.f_year = ($urandom_range(9) == 0) ? 16'($urandom)
                 : (r.kind == KIND_SET) ? 16'($signed($urandom_range(4000)) - 2000)
                 : 16'($urandom_range(40));
      r.f_month  = pick_arg(11);
      r.f_day    = pick_arg(30);
      r.f_hour   = pick_arg(23);
      r.f_minute = pick_arg(59);
      r.f_second = pick_arg(59);
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_requests.size() > 0 || req_tvalid || expected_stamps.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      cal_year = 2000; cal_month = 0; cal_day = 0;
      cal_hour = 0; cal_minute = 0; cal_second = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: leap rules, month ends, borrows, wraps, extremes, keep
      pending_requests.push_back(make_request(KIND_KEEP, 0, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(KIND_SET, 2024, 1, 28, 23, 59, 59));
      pending_requests.push_back(make_request(KIND_ADD, 0, 0, 0, 0, 0, 1));
      pending_requests.push_back(make_request(KIND_SUB, 0, 0, 0, 0, 0, 1));
      pending_requests.push_back(make_request(KIND_SET, 1900, 1, 28, 0, 0, 0));
      pending_requests.push_back(make_request(KIND_SET, 2000, 11, 30, 23, 59, 59));
      pending_requests.push_back(make_request(KIND_ADD, 0, 0, 0, 0, 0, 1));
      pending_requests.push_back(make_request(KIND_SET, 0, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(KIND_SUB, 0, 0, 0, 0, 0, 1));
      pending_requests.push_back(make_request(KIND_SET, 16'h7FFF, 11, 30, 23, 59, 59));
      pending_requests.push_back(make_request(KIND_ADD, 0, 0, 0, 0, 0, 1));
      pending_requests.push_back(make_request(KIND_SUB, 16'h7FFF, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(KIND_SET, 16'h8000, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(KIND_SUB, 0, 0, 366, 0, 0, 0));
      pending_requests.push_back(make_request(KIND_SET, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                              16'hFFFF, 16'hFFFF, 16'hFFFF));
      pending_requests.push_back(make_request(KIND_ADD, 16'h7FFF, 16'hFFFF, 16'hFFFF,
                                              16'hFFFF, 16'hFFFF, 16'hFFFF));
      pending_requests.push_back(make_request(KIND_SUB, 16'h8000, 16'hFFFF, 16'hFFFF,
                                              16'hFFFF, 16'hFFFF, 16'hFFFF));
      pending_requests.push_back(make_request(KIND_SET, 2023, 14, 400, 30, 70, 90));
      pending_requests.push_back(make_request(KIND_SUB, 5, 30, 1000, 100, 200, 300));
      pending_requests.push_back(make_request(KIND_SET, 2001, 5, 30, 0, 0, 0));
      pending_requests.push_back(make_request(KIND_KEEP, 16'hFFFF, 0, 0, 0, 0, 0));
      wait_drained();

      // hold requests until the block has drained completely
      for (int i = 0; i < 30; i++) pending_requests.push_back(random_request());
      while (pending_requests.size() >= 15) @(posedge clock);
      hold_requests = 1'b1;
      while (req_tvalid || expected_stamps.size() > 0) @(posedge clock);
      hold_requests = 1'b0;

      for (int i = 0; i < 270; i++) pending_requests.push_back(random_request());
      wait_drained();
      send_idle_pct = 58;
      recv_idle_pct = 30;
      for (int i = 0; i < 300; i++) pending_requests.push_back(random_request());
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 300; i++) pending_requests.push_back(random_request());
      wait_drained();
      repeat (500) @(posedge clock);

      $display("Sent %0d requests (set, add, subtract, keep) and checked %0d results",
               sent_count, checked_count);
      $display("across three handshake idle mixes, including leap and year wrap cases");
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #20000000;
      $display("Timeout with %0d results still expected", expected_stamps.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

>>> date_time_normalizing_adder_core.f
src/dtna_pkg.sv
src/dtna_div.sv
src/dtna_datapath.sv
src/dtna_ctrl.sv
src/date_time_normalizing_adder_core.sv
sim/date_time_normalizing_adder_core_tb.sv
